// File: rtl/jmdp_pkg.sv
// ----------------------------------------------------------------------------
// jmdp_pkg: shared types and constants for the jet/MET min delta-phi block
// Word layouts of both channels, register codes, reset values and the
// fixed-point pi helper.
// ----------------------------------------------------------------------------
package jmdp_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 10;
    localparam int ANGLE_W             = 16;
    localparam int MIN_W               = 15;
    localparam int DR2_W               = 33;
    localparam int CFG_DATA_W          = 24;
    localparam int CFG_IDX_W           = 3;

    // pi in 2^-20 units; scaled down with round half up
    localparam int PI_Q20 = 3294199;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERLAP_DR2_LIMIT = 3'd0,
        CFG_GOOD_PT_MIN       = 3'd1,
        CFG_GOOD_ETA_MAX      = 3'd2,
        CFG_VETO_ETA_MAX      = 3'd3,
        CFG_VETO_PHI_MAX      = 3'd4,
        CFG_START_MINIMUM     = 3'd5
    } cfg_reg_t;

    localparam logic [23:0] RST_OVERLAP_DR2_LIMIT = 24'd419430;
    localparam logic [15:0] RST_GOOD_PT_MIN       = 16'd80;
    localparam logic [14:0] RST_GOOD_ETA_MAX      = 15'd5120;
    localparam logic [14:0] RST_VETO_ETA_MAX      = 15'd10240;
    localparam logic [14:0] RST_VETO_PHI_MAX      = 15'd6434;
    localparam logic [14:0] RST_START_MINIMUM     = 15'd3686;

    // item word: mode 0 header, 1 jet
    typedef struct packed {
        logic                      mode;
        logic                      end_of_event;
        logic signed [ANGLE_W-1:0] lep1_eta;
        logic signed [ANGLE_W-1:0] lep1_phi;
        logic signed [ANGLE_W-1:0] lep2_eta;
        logic signed [ANGLE_W-1:0] lep2_phi;
        logic signed [ANGLE_W-1:0] met_phi;
        logic signed [ANGLE_W-1:0] jet_eta;
        logic signed [ANGLE_W-1:0] jet_phi;
        logic        [15:0]        jet_pt;
        logic signed [3:0]         jet_quality;
    } item_t;

    typedef struct packed {
        logic [MIN_W-1:0] min_dphi_all;
        logic [MIN_W-1:0] min_dphi_loose;
        logic [MIN_W-1:0] min_dphi_good;
    } result_t;

    // pi at the given number of fraction bits, rounded half up
    function automatic int pi_fix(input int frac_bits);
        return (PI_Q20 + (1 << (19 - frac_bits))) >> (20 - frac_bits);
    endfunction

endpackage

// File: rtl/jmdp_if.sv
// ----------------------------------------------------------------------------
// jmdp_item_if / jmdp_result_if: valid/ready channels
// Item channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface jmdp_item_if;
    import jmdp_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jmdp_result_if;
    import jmdp_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/jmdp_dr2.sv
// ----------------------------------------------------------------------------
// jmdp_dr2: squared delta-R between a jet and one lepton
// Three register stages: phi wrap quotient, wrap remainder, squares.
// Output is the sum of the registered squares.
// ----------------------------------------------------------------------------
module jmdp_dr2 #(
    parameter int ANGLE_FRAC_BITS = jmdp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [jmdp_pkg::ANGLE_W-1:0] jet_eta,
    input  logic signed [jmdp_pkg::ANGLE_W-1:0] jet_phi,
    input  logic signed [jmdp_pkg::ANGLE_W-1:0] lep_eta,
    input  logic signed [jmdp_pkg::ANGLE_W-1:0] lep_phi,
    output logic        [jmdp_pkg::DR2_W-1:0]   dr2
);
    import jmdp_pkg::*;

    localparam int PI_FIX   = pi_fix(ANGLE_FRAC_BITS);
    localparam int TWO_PI   = 2 * PI_FIX;
    localparam int SPAN     = 2 ** ANGLE_W;
    // multiple of 2pi that keeps the wrap operand positive
    localparam int WRAP_OFS = TWO_PI * ((SPAN + TWO_PI - 1) / TWO_PI);
    localparam int X_MAX    = SPAN - 1 + PI_FIX + WRAP_OFS;
    localparam int XW       = $clog2(X_MAX + 1);
    localparam int RECIP    = (2 ** XW) / TWO_PI;
    localparam int RW       = $clog2(RECIP + 1);
    localparam int QW       = $clog2(X_MAX / TWO_PI + 1);
    localparam int PW       = $clog2(PI_FIX + 1) + 1;
    localparam int DW       = ANGLE_W + 1;
    localparam int SQE_W    = 2 * ANGLE_W;
    localparam int SQP_W    = 2 * PW - 1;

    // stage 1: differences and quotient estimate (exact or one low)
    logic signed [DW-1:0]    de;
    logic signed [DW-1:0]    dphi;
    logic signed [XW:0]      x_s;
    logic        [XW-1:0]    x;
    logic        [XW+RW-1:0] prod;

    assign de   = DW'(jet_eta) - DW'(lep_eta);
    assign dphi = DW'(jet_phi) - DW'(lep_phi);
    assign x_s  = (XW+1)'(dphi) + $signed((XW+1)'(PI_FIX + WRAP_OFS));
    assign x    = x_s[XW-1:0];
    assign prod = (XW+RW)'(x) * (XW+RW)'(RECIP);

    logic signed [DW-1:0] de_s2_reg;
    logic        [XW-1:0] x_s2_reg;
    logic        [QW-1:0] q_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            de_s2_reg <= de;
            x_s2_reg  <= x;
            q_s2_reg  <= prod[XW +: QW];
        end
    end

    // stage 2: remainder, one correction, recenter to [-pi, pi)
    logic        [XW-1:0] qc;
    logic        [XW-1:0] r0;
    logic        [XW-1:0] r1;
    logic signed [PW:0]   dp_w;

    assign qc   = XW'(q_s2_reg) * XW'(TWO_PI);
    assign r0   = x_s2_reg - qc;
    assign r1   = (r0 >= XW'(TWO_PI)) ? r0 - XW'(TWO_PI) : r0;
    assign dp_w = $signed({1'b0, r1[PW-1:0]}) - $signed((PW+1)'(PI_FIX));

    logic signed [DW-1:0] de_s3_reg;
    logic signed [PW-1:0] dp_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            de_s3_reg <= de_s2_reg;
            dp_s3_reg <= dp_w[PW-1:0];
        end
    end

    // stage 3: squares
    logic signed [2*DW-1:0] sq_e_full;
    logic signed [2*PW-1:0] sq_p_full;

    assign sq_e_full = de_s3_reg * de_s3_reg;
    assign sq_p_full = dp_s3_reg * dp_s3_reg;

    logic [SQE_W-1:0] sq_e_reg;
    logic [SQP_W-1:0] sq_p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_e_reg <= sq_e_full[SQE_W-1:0];
            sq_p_reg <= sq_p_full[SQP_W-1:0];
        end
    end

    assign dr2 = DR2_W'(sq_e_reg) + DR2_W'(sq_p_reg);

endmodule

// File: rtl/jet_met_min_delta_phi.sv
// ----------------------------------------------------------------------------
// jet_met_min_delta_phi: per-event minimum jet-to-MET delta-phi
// Header words load lepton and MET angles and restart three minima; jet
// words are vetoed, checked for lepton overlap and fold their delta-phi in.
// ----------------------------------------------------------------------------
// Usage
//   item   : valid/ready sink. mode 0 = event header (lepton eta/phi, MET
//            phi), mode 1 = jet. end_of_event marks the last word of an event.
//   result : valid/ready source, one word per end_of_event word, holding the
//            all / loose / good minima in 1/2^ANGLE_FRAC_BITS rad.
//   cfg_*  : register writes (cfg_write, cfg_index, cfg_data), only while
//            the block is idle. Indexes past the last register are dropped.
// Timing
//   One word accepted per cycle while the pipeline is not held. A result is
//   valid once the last word of its event has passed the input register,
//   the phi wrap quotient, wrap remainder and squares registers of the
//   delta-R pipeline, then the overlap compare and minimum update into the
//   result register. The minima live only at the final stage, so a jet may
//   follow a jet or a header in the next cycle.
// Reset
//   Registers take their default values, lepton and MET angles clear to 0,
//   the minima load the default start value, both channels go empty.
// Stall
//   While a finished result waits in the result register, the pipeline keeps
//   moving; it holds only when the next result reaches the final stage.
// ----------------------------------------------------------------------------
module jet_met_min_delta_phi #(
    parameter int ANGLE_FRAC_BITS = jmdp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    jmdp_item_if.sink                          item,
    jmdp_result_if.source                      result,
    input  logic                               cfg_write,
    input  logic [jmdp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jmdp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import jmdp_pkg::*;

    localparam int PI_FIX = pi_fix(ANGLE_FRAC_BITS);
    localparam int TWO_PI = 2 * PI_FIX;
    localparam int AW     = ANGLE_W + 1;   // width of an angle magnitude

    // per-jet decisions that ride along with the delta-R pipeline
    typedef struct packed {
        logic              is_jet;
        logic              last;
        logic              pass;     // inside the veto window
        logic              loose;
        logic              good;
        logic [ANGLE_W-1:0] dphi;    // folded jet-to-MET delta-phi
    } jet_flags_t;

    function automatic logic [AW-1:0] abs_angle(input logic signed [ANGLE_W-1:0] v);
        logic signed [AW-1:0] w;
        w = AW'(v);
        return w[AW-1] ? AW'(-w) : AW'(w);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [23:0]      overlap_limit_reg;
    logic [15:0]      good_pt_min_reg;
    logic [14:0]      good_eta_max_reg;
    logic [14:0]      veto_eta_max_reg;
    logic [14:0]      veto_phi_max_reg;
    logic [MIN_W-1:0] start_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_limit_reg <= RST_OVERLAP_DR2_LIMIT;
            good_pt_min_reg   <= RST_GOOD_PT_MIN;
            good_eta_max_reg  <= RST_GOOD_ETA_MAX;
            veto_eta_max_reg  <= RST_VETO_ETA_MAX;
            veto_phi_max_reg  <= RST_VETO_PHI_MAX;
            start_min_reg     <= RST_START_MINIMUM;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OVERLAP_DR2_LIMIT: overlap_limit_reg <= cfg_data[23:0];
                CFG_GOOD_PT_MIN:       good_pt_min_reg   <= cfg_data[15:0];
                CFG_GOOD_ETA_MAX:      good_eta_max_reg  <= cfg_data[14:0];
                CFG_VETO_ETA_MAX:      veto_eta_max_reg  <= cfg_data[14:0];
                CFG_VETO_PHI_MAX:      veto_phi_max_reg  <= cfg_data[14:0];
                CFG_START_MINIMUM:     start_min_reg     <= cfg_data[MIN_W-1:0];
                default:               ;   // unknown index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance
    // Everything moves together; only a result that cannot be stored
    // holds the pipe.
    // ------------------------------------------------------------------
    logic       en;
    logic       accept;
    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    jet_flags_t s2_flags_reg, s3_flags_reg, s4_flags_reg;
    logic       out_valid_reg;

    assign en         = !(s4_valid_reg && s4_flags_reg.last) || !out_valid_reg || result.ready;
    assign item.ready = en;
    assign accept     = item.valid && en;

    // ------------------------------------------------------------------
    // Event header state: captured at acceptance so the next jet, even
    // one accepted right behind the header, sees it in stage 1.
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] lep_a_eta_reg, lep_a_phi_reg;
    logic signed [ANGLE_W-1:0] lep_b_eta_reg, lep_b_phi_reg;
    logic signed [ANGLE_W-1:0] met_phi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lep_a_eta_reg <= '0;
            lep_a_phi_reg <= '0;
            lep_b_eta_reg <= '0;
            lep_b_phi_reg <= '0;
            met_phi_reg   <= '0;
        end
        else if (accept && !item.data.mode)
        begin
            lep_a_eta_reg <= item.data.lep1_eta;
            lep_a_phi_reg <= item.data.lep1_phi;
            lep_b_eta_reg <= item.data.lep2_eta;
            lep_b_phi_reg <= item.data.lep2_phi;
            met_phi_reg   <= item.data.met_phi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                      s1_mode_reg;
    logic                      s1_last_reg;
    logic signed [ANGLE_W-1:0] s1_eta_reg;
    logic signed [ANGLE_W-1:0] s1_phi_reg;
    logic        [15:0]        s1_pt_reg;
    logic signed [3:0]         s1_quality_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg    <= item.data.mode;
            s1_last_reg    <= item.data.end_of_event;
            s1_eta_reg     <= item.data.jet_eta;
            s1_phi_reg     <= item.data.jet_phi;
            s1_pt_reg      <= item.data.jet_pt;
            s1_quality_reg <= item.data.jet_quality;
        end
    end

    // cuts and folded delta-phi to MET
    logic [AW-1:0]         abs_eta;
    logic [AW-1:0]         abs_phi;
    logic signed [AW-1:0]  met_diff;
    logic [AW-1:0]         fold_abs;
    logic signed [AW:0]    fold_wrap;
    logic [AW-1:0]         fold_d;
    jet_flags_t            s1_flags;

    always_comb
    begin
        abs_eta   = abs_angle(s1_eta_reg);
        abs_phi   = abs_angle(s1_phi_reg);
        met_diff  = AW'(s1_phi_reg) - AW'(met_phi_reg);
        fold_abs  = met_diff[AW-1] ? AW'(-met_diff) : AW'(met_diff);
        fold_wrap = $signed({1'b0, fold_abs}) - $signed((AW+1)'(TWO_PI));
        // one fold only: |d - 2pi| when d is past pi
        if (fold_abs > AW'(PI_FIX))
            fold_d = fold_wrap[AW] ? AW'(-fold_wrap) : AW'(fold_wrap);
        else
            fold_d = fold_abs;

        s1_flags.is_jet = s1_mode_reg;
        s1_flags.last   = s1_last_reg;
        s1_flags.pass   = (abs_eta <= AW'(veto_eta_max_reg)) &&
                          (abs_phi <= AW'(veto_phi_max_reg));
        s1_flags.loose  = !s1_quality_reg[3] && (s1_quality_reg != 4'sd0);
        s1_flags.good   = (s1_pt_reg > good_pt_min_reg) &&
                          (abs_eta < AW'(good_eta_max_reg));
        s1_flags.dphi   = fold_d[ANGLE_W-1:0];
    end

    // delta-R^2 to each lepton, result aligned with stage 4
    logic [DR2_W-1:0] dr2_a;
    logic [DR2_W-1:0] dr2_b;

    jmdp_dr2 #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dr2_a (
        .clk     (clk),
        .en      (en),
        .jet_eta (s1_eta_reg),
        .jet_phi (s1_phi_reg),
        .lep_eta (lep_a_eta_reg),
        .lep_phi (lep_a_phi_reg),
        .dr2     (dr2_a)
    );

    jmdp_dr2 #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dr2_b (
        .clk     (clk),
        .en      (en),
        .jet_eta (s1_eta_reg),
        .jet_phi (s1_phi_reg),
        .lep_eta (lep_b_eta_reg),
        .lep_phi (lep_b_phi_reg),
        .dr2     (dr2_b)
    );

    // ------------------------------------------------------------------
    // Stages 2..4: flags follow the delta-R pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= item.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_flags_reg <= s1_flags;
            s3_flags_reg <= s2_flags_reg;
            s4_flags_reg <= s3_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: overlap test and running minima
    // ------------------------------------------------------------------
    logic [MIN_W-1:0] min_all_reg,  min_all_next;
    logic [MIN_W-1:0] min_loose_reg, min_loose_next;
    logic [MIN_W-1:0] min_good_reg, min_good_next;
    logic             overlap;
    logic             take;
    logic             lt_all, lt_loose, lt_good;
    logic             emit;

    assign overlap  = (dr2_a < DR2_W'(overlap_limit_reg)) ||
                      (dr2_b < DR2_W'(overlap_limit_reg));
    assign take     = s4_flags_reg.is_jet && s4_flags_reg.pass && !overlap;
    assign lt_all   = s4_flags_reg.dphi < ANGLE_W'(min_all_reg);
    assign lt_loose = s4_flags_reg.dphi < ANGLE_W'(min_loose_reg);
    assign lt_good  = s4_flags_reg.dphi < ANGLE_W'(min_good_reg);
    assign emit     = en && s4_valid_reg && s4_flags_reg.last;

    always_comb
    begin
        min_all_next   = min_all_reg;
        min_loose_next = min_loose_reg;
        min_good_next  = min_good_reg;
        if (s4_valid_reg)
        begin
            if (!s4_flags_reg.is_jet)
            begin
                // header restarts the event
                min_all_next   = start_min_reg;
                min_loose_next = start_min_reg;
                min_good_next  = start_min_reg;
            end
            else if (take)
            begin
                // a value below a minimum always fits the minimum's width
                if (lt_all)
                    min_all_next = s4_flags_reg.dphi[MIN_W-1:0];
                if (s4_flags_reg.loose && lt_loose)
                    min_loose_next = s4_flags_reg.dphi[MIN_W-1:0];
                if (s4_flags_reg.loose && s4_flags_reg.good && lt_good)
                    min_good_next = s4_flags_reg.dphi[MIN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_all_reg   <= RST_START_MINIMUM;
            min_loose_reg <= RST_START_MINIMUM;
            min_good_reg  <= RST_START_MINIMUM;
        end
        else if (en)
        begin
            min_all_reg   <= min_all_next;
            min_loose_reg <= min_loose_next;
            min_good_reg  <= min_good_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic    out_valid_next;
    result_t out_data_reg;

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.min_dphi_all   <= min_all_next;
            out_data_reg.min_dphi_loose <= min_loose_next;
            out_data_reg.min_dphi_good  <= min_good_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for jet_met_min_delta_phi
// Drives header and jet words through the item channel and compares every
// result word against a typed-in value or an in-bench model of the three
// per-event minima. A short directed table runs first, then phases of random
// events under changing register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import jmdp_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int PIPE_LATENCY    = 4;                 // stages s1 to s4 of the block
    localparam int DRAIN_CYCLES    = 3 * PIPE_LATENCY;  // margin for result-less words
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 200;
    localparam int PRINT_CAP       = 100;

    // pi at the default fraction width, rounded half up, and its double
    localparam int PI_FIX     = (PI_Q20 + (1 << (19 - ANGLE_FRAC_BITS_DEF)))
                                >> (20 - ANGLE_FRAC_BITS_DEF);
    localparam int TWO_PI_FIX = 2 * PI_FIX;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_JET    = 1'b1;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam result_t START_RESULT = '{RST_START_MINIMUM, RST_START_MINIMUM,
                                         RST_START_MINIMUM};

    // directed table row: the word and, where obvious, its typed-in result
    typedef struct {
        item_t   word;
        bit      typed;
        result_t want;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    jmdp_item_if   item_bus ();
    jmdp_result_if result_bus ();

    always #HALF_PERIOD clk = ~clk;

    jet_met_min_delta_phi DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Model state: register copies, event angles, running minima
    // ------------------------------------------------------------------------
    logic [23:0] dr2_limit_q;
    logic [15:0] pt_min_q;
    logic [14:0] good_eta_q;
    logic [14:0] veto_eta_q;
    logic [14:0] veto_phi_q;
    logic [14:0] start_min_q;

    int lep_a_eta, lep_a_phi, lep_b_eta, lep_b_phi, met_phi_q;
    int min_all, min_loose, min_good;

    result_t   minima_due[$];   // expected result words, oldest first
    stim_row_t directed[$];

    int cycles = 0;
    int errors = 0;
    int gap_pct;         // chance per word of a gap on the item side
    int stall_pct;       // chance per cycle of a stall on the result side
    int stall_left = 0;

    // event angles of the random generator, used to aim jets at leptons
    int ev_l1e, ev_l1p, ev_l2e, ev_l2p;

    // ------------------------------------------------------------------------
    // Angle helpers
    // ------------------------------------------------------------------------

    // wrap a phi difference into [-pi, pi); % truncates toward zero as in C
    function automatic int wrap_angle(input int d);
        int t;
        t = (d + PI_FIX) % TWO_PI_FIX;
        if (t < 0)
            t += TWO_PI_FIX;
        return t - PI_FIX;
    endfunction

    // squared delta-R, eta difference unwrapped, phi difference wrapped
    function automatic longint sep2(input int eta, input int phi,
                                    input int leta, input int lphi);
        longint de;
        longint dp;
        de = longint'(eta - leta);
        dp = longint'(wrap_angle(phi - lphi));
        return de * de + dp * dp;
    endfunction

    // jet-to-MET delta-phi, folded once only; can exceed pi for odd angles
    function automatic int fold_to_met(input int a, input int b);
        int d;
        d = a - b;
        if (d < 0)
            d = -d;
        if (d > PI_FIX)
        begin
            d = d - TWO_PI_FIX;
            if (d < 0)
                d = -d;
        end
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: consumes one accepted word, returns 1 when it closes an
    // event, with the three minima in r
    // ------------------------------------------------------------------------
    function automatic bit predict_minima(input item_t w, output result_t r);
        int eta, phi, aeta, aphi, dphi;
        bit overlap, loose, good;
        if (w.mode == MODE_HEADER)
        begin
            lep_a_eta = int'($signed(w.lep1_eta));
            lep_a_phi = int'($signed(w.lep1_phi));
            lep_b_eta = int'($signed(w.lep2_eta));
            lep_b_phi = int'($signed(w.lep2_phi));
            met_phi_q = int'($signed(w.met_phi));
            min_all   = int'(start_min_q);
            min_loose = int'(start_min_q);
            min_good  = int'(start_min_q);
        end
        else
        begin
            eta  = int'($signed(w.jet_eta));
            phi  = int'($signed(w.jet_phi));
            aeta = (eta < 0) ? -eta : eta;
            aphi = (phi < 0) ? -phi : phi;
            // veto window is inclusive on both edges
            if (aeta <= int'(veto_eta_q) && aphi <= int'(veto_phi_q))
            begin
                overlap = sep2(eta, phi, lep_a_eta, lep_a_phi) < longint'(dr2_limit_q) ||
                          sep2(eta, phi, lep_b_eta, lep_b_phi) < longint'(dr2_limit_q);
                loose   = int'($signed(w.jet_quality)) > 0;
                good    = (w.jet_pt > pt_min_q) && (aeta < int'(good_eta_q));
                dphi    = fold_to_met(phi, met_phi_q);
                if (!overlap)
                begin
                    if (dphi < min_all)
                        min_all = dphi;
                    if (loose && dphi < min_loose)
                        min_loose = dphi;
                    if (loose && good && dphi < min_good)
                        min_good = dphi;
                end
            end
        end
        r.min_dphi_all   = min_all[MIN_W-1:0];
        r.min_dphi_loose = min_loose[MIN_W-1:0];
        r.min_dphi_good  = min_good[MIN_W-1:0];
        return w.end_of_event;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders; fields a word does not use get random filler
    // ------------------------------------------------------------------------
    function automatic item_t make_header(input logic eoe, input int l1e, input int l1p,
                                          input int l2e, input int l2p, input int met);
        item_t w;
        w.mode         = MODE_HEADER;
        w.end_of_event = eoe;
        w.lep1_eta     = 16'(l1e);
        w.lep1_phi     = 16'(l1p);
        w.lep2_eta     = 16'(l2e);
        w.lep2_phi     = 16'(l2p);
        w.met_phi      = 16'(met);
        w.jet_eta      = 16'($urandom);
        w.jet_phi      = 16'($urandom);
        w.jet_pt       = 16'($urandom);
        w.jet_quality  = 4'($urandom);
        return w;
    endfunction

    function automatic item_t make_jet(input logic eoe, input int eta, input int phi,
                                       input int pt, input int q);
        item_t w;
        w.mode         = MODE_JET;
        w.end_of_event = eoe;
        w.lep1_eta     = 16'($urandom);
        w.lep1_phi     = 16'($urandom);
        w.lep2_eta     = 16'($urandom);
        w.lep2_phi     = 16'($urandom);
        w.met_phi      = 16'($urandom);
        w.jet_eta      = 16'(eta);
        w.jet_phi      = 16'(phi);
        w.jet_pt       = 16'(pt);
        w.jet_quality  = 4'(q);
        return w;
    endfunction

    // symmetric random value in [-span, span]
    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // idle length: usually short, one time in twenty a long stretch
    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(10, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting; printing capped, counting not
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("[%0d] MISMATCH: %s", cycles, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Cycle counter and timeout
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, driven at the falling edge
    // ------------------------------------------------------------------------
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (stall_pct != 0 && int'($urandom_range(0, 99)) < stall_pct)
            begin
                result_bus.ready <= 1'b0;
                stall_left = idle_len() - 1;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = result_bus.data;
            if (minima_due.size() == 0)
            begin
                report_mismatch($sformatf("result %0d/%0d/%0d with nothing due",
                                          got.min_dphi_all, got.min_dphi_loose,
                                          got.min_dphi_good));
            end
            else
            begin
                want = minima_due.pop_front();
                if (got.min_dphi_all !== want.min_dphi_all)
                    report_mismatch($sformatf("min_dphi_all got %0d want %0d",
                                              got.min_dphi_all, want.min_dphi_all));
                if (got.min_dphi_loose !== want.min_dphi_loose)
                    report_mismatch($sformatf("min_dphi_loose got %0d want %0d",
                                              got.min_dphi_loose, want.min_dphi_loose));
                if (got.min_dphi_good !== want.min_dphi_good)
                    report_mismatch($sformatf("min_dphi_good got %0d want %0d",
                                              got.min_dphi_good, want.min_dphi_good));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item side driver: optional gap, then hold the word until accepted.
    // valid stays high between back-to-back words.
    // ------------------------------------------------------------------------
    task automatic send_word(input item_t w, input bit typed, input result_t typed_res);
        int      gap;
        result_t r;
        gap = 0;
        if (gap_pct != 0 && int'($urandom_range(0, 99)) < gap_pct)
            gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            item_bus.valid <= 1'b0;
        end
        @(negedge clk);
        item_bus.valid <= 1'b1;
        item_bus.data  <= w;
        do
            @(posedge clk);
        while (!item_bus.ready);
        // accepted at this edge
        if (predict_minima(w, r))
            minima_due.push_back(typed ? typed_res : r);
    endtask

    // lower valid, wait out every expected result, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (minima_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write; the model copy follows at the write edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_OVERLAP_DR2_LIMIT: dr2_limit_q = val;
            CFG_GOOD_PT_MIN:       pt_min_q    = val[15:0];
            CFG_GOOD_ETA_MAX:      good_eta_q  = val[14:0];
            CFG_VETO_ETA_MAX:      veto_eta_q  = val[14:0];
            CFG_VETO_PHI_MAX:      veto_phi_q  = val[14:0];
            CFG_START_MINIMUM:     start_min_q = val[14:0];
            default: ;  // spare index, dropped
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_setting(input int lim, input int ptm, input int gem,
                                 input int vem, input int vpm, input int stm);
        write_reg(CFG_OVERLAP_DR2_LIMIT, 24'(lim));
        write_reg(CFG_GOOD_PT_MIN,       24'(ptm));
        write_reg(CFG_GOOD_ETA_MAX,      24'(gem));
        write_reg(CFG_VETO_ETA_MAX,      24'(vem));
        write_reg(CFG_VETO_PHI_MAX,      24'(vpm));
        write_reg(CFG_START_MINIMUM,     24'(stm));
    endtask

    // ------------------------------------------------------------------------
    // Random word: mostly well-formed events with random content, some noise
    // (any field, any value) that also breaks the event framing
    // ------------------------------------------------------------------------
    function automatic item_t random_word(inout int jets_left);
        item_t w;
        int    eta, phi, pt, met;
        logic  eoe;
        if (int'($urandom_range(0, 99)) < 8)
        begin
            w.mode         = 1'($urandom);
            w.end_of_event = 1'($urandom);
            w.lep1_eta     = 16'($urandom);
            w.lep1_phi     = 16'($urandom);
            w.lep2_eta     = 16'($urandom);
            w.lep2_phi     = 16'($urandom);
            w.met_phi      = 16'($urandom);
            w.jet_eta      = 16'($urandom);
            w.jet_phi      = 16'($urandom);
            w.jet_pt       = 16'($urandom);
            w.jet_quality  = 4'($urandom);
            return w;
        end
        if (jets_left < 0)
        begin
            // new event: normal angles mostly, full range now and then
            if ($urandom_range(0, 9) == 0)
            begin
                ev_l1e = int'($signed(16'($urandom)));
                ev_l1p = int'($signed(16'($urandom)));
                ev_l2e = int'($signed(16'($urandom)));
                ev_l2p = int'($signed(16'($urandom)));
                met    = int'($signed(16'($urandom)));
            end
            else
            begin
                ev_l1e = spread(6000);
                ev_l1p = spread(PI_FIX);
                ev_l2e = spread(6000);
                ev_l2p = spread(PI_FIX);
                met    = spread(PI_FIX);
            end
            jets_left = int'($urandom_range(0, 6));
            eoe = (jets_left == 0);
            if (eoe)
                jets_left = -1;
            return make_header(eoe, ev_l1e, ev_l1p, ev_l2e, ev_l2p, met);
        end
        // jet of the open event
        jets_left--;
        eoe = (jets_left == 0);
        if (eoe)
            jets_left = -1;
        case ($urandom_range(0, 9))
            0, 1:
            begin   // aimed at the first lepton
                eta = ev_l1e + spread(800);
                phi = ev_l1p + spread(800);
            end
            2:
            begin   // aimed at the second lepton
                eta = ev_l2e + spread(800);
                phi = ev_l2p + spread(800);
            end
            3:
            begin   // around the veto edges
                eta = spread(12000);
                phi = spread(7000);
            end
            default:
            begin
                eta = spread(8000);
                phi = spread(PI_FIX);
            end
        endcase
        pt = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(0, 300));
        return make_jet(eoe, eta, phi, pt, int'($urandom_range(0, 15)));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int    i;
        int    p;
        int    n;
        int    jets_left;
        item_t w;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        item_bus.valid = 1'b0;
        item_bus.data  = '0;
        gap_pct        = 0;
        stall_pct      = 0;

        // model reset state mirrors the block's
        dr2_limit_q = RST_OVERLAP_DR2_LIMIT;
        pt_min_q    = RST_GOOD_PT_MIN;
        good_eta_q  = RST_GOOD_ETA_MAX;
        veto_eta_q  = RST_VETO_ETA_MAX;
        veto_phi_q  = RST_VETO_PHI_MAX;
        start_min_q = RST_START_MINIMUM;
        lep_a_eta   = 0;
        lep_a_phi   = 0;
        lep_b_eta   = 0;
        lep_b_phi   = 0;
        met_phi_q   = 0;
        min_all     = int'(RST_START_MINIMUM);
        min_loose   = int'(RST_START_MINIMUM);
        min_good    = int'(RST_START_MINIMUM);

        // --------------------------------------------------------------------
        // Directed table, run with the reset register values
        // --------------------------------------------------------------------
        // jet before any header: leptons at zero, so a jet at the origin
        // overlaps and the reset minima come out
        directed.push_back('{make_jet(1'b1, 0, 0, 100, 1), 1'b1, START_RESULT});
        // header that closes its own event emits the start values
        directed.push_back('{make_header(1'b1, 0, 0, 0, 0, 0), 1'b1, START_RESULT});
        // plain event: good, loose-only, non-loose, overlapping jets
        directed.push_back('{make_header(1'b0, 3000, 1000, -3000, -2000, 0), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 0, 400, 200, 1), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 0, -300, 50, 1), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 0, 200, 200, 0), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 0, 150, 200, -1), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 3000, 1000, 200, 7), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, -3100, -2100, 200, 3), 1'b0, '0});
        // vetoed jet that closes the event still emits
        directed.push_back('{make_jet(1'b1, 12000, 0, 200, 1), 1'b0, '0});
        // extreme header angles, jets on and just past the veto edges
        directed.push_back('{make_header(1'b0, -32768, 32767, 32767, -32768, 32767),
                             1'b0, '0});
        directed.push_back('{make_jet(1'b0, 10240, -6434, 65535, 7), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, -10241, 0, 200, 1), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 0, 6435, 200, 1), 1'b0, '0});
        directed.push_back('{make_jet(1'b1, -32768, -32768, 0, -8), 1'b0, '0});
        // MET at -pi: a jet at +pi folds to zero; pt and eta cut edges
        directed.push_back('{make_header(1'b0, 20000, 0, 20000, 0, -PI_FIX), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 0, PI_FIX, 81, 1), 1'b0, '0});
        directed.push_back('{make_jet(1'b1, 5120, 0, 80, 1), 1'b0, '0});
        // leptons at +pi and -pi: a jet at -pi overlaps both, the one at +pi through the phi wrap
        directed.push_back('{make_header(1'b0, 0, PI_FIX, 0, -PI_FIX, 0), 1'b0, '0});
        directed.push_back('{make_jet(1'b0, 0, -PI_FIX, 200, 1), 1'b0, '0});
        directed.push_back('{make_jet(1'b1, 600, 0, 200, 1), 1'b0, '0});
        directed.push_back('{make_header(1'b1, 32767, -32768, -32768, 32767, -32768),
                             1'b1, START_RESULT});

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        for (i = 0; i < directed.size(); i++)
            send_word(directed[i].word, directed[i].typed, directed[i].want);
        settle();

        // --------------------------------------------------------------------
        // Random phases. A phase may end in mid-event, so a register change
        // (start_minimum included) can land between the words of one event.
        // --------------------------------------------------------------------
        jets_left = -1;
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // reset values stay; spare indexes must change nothing
                    write_reg(CFG_SPARE_LO, 24'($urandom));
                    write_reg(CFG_SPARE_HI, 24'($urandom));
                end
                1: apply_setting(0, 0, 0, 32767, 32767, 32767);
                2: apply_setting(16777215, 65535, 32767, 0, 0, 0);
                3: apply_setting(int'(RST_OVERLAP_DR2_LIMIT), int'(RST_GOOD_PT_MIN),
                                 int'(RST_GOOD_ETA_MAX), int'(RST_VETO_ETA_MAX),
                                 int'(RST_VETO_PHI_MAX), int'(RST_START_MINIMUM));
                default:
                begin
                    apply_setting(int'($urandom_range(0, 2000000)),
                                  int'($urandom_range(0, 300)),
                                  int'($urandom_range(0, 10000)),
                                  int'($urandom_range(3000, 32767)),
                                  int'($urandom_range(2000, 32767)),
                                  int'($urandom_range(500, 32767)));
                    write_reg(CFG_SPARE_HI, 24'($urandom));
                end
            endcase

            // every fourth phase runs flat out on both sides
            if (p % 4 == 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = int'($urandom_range(5, 40));
                stall_pct = int'($urandom_range(5, 40));
            end

            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                w = random_word(jets_left);
                send_word(w, 1'b0, '0);
            end
            settle();
        end

        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
